FILE: design/cglc_pkg.sv
// Package: shared types and constants for the click gesture LED chaser.
`timescale 1ns / 1ps
package cglc_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned PortW = 8;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);

  localparam logic [CntW-1:0] ShiftPeriodRst = 16'd2000;
  localparam logic [CntW-1:0] BlinkPeriodRst = 16'd4000;
  localparam logic [CntW-1:0] LongPressRst = 16'd4000;
  localparam logic [CntW-1:0] DoubleWindowRst = 16'd2000;
  localparam logic [PortW-1:0] PatternRst = 8'hFE;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_SINGLE = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_LONG   = 2'd3
  } gesture_e;

  typedef enum logic [1:0] {
    KEY_WAIT_PRESS   = 2'd0,
    KEY_HELD         = 2'd1,
    KEY_WAIT_SECOND  = 2'd2,
    KEY_WAIT_RELEASE = 2'd3
  } key_phase_e;

  typedef enum logic [1:0] {
    RUN_IDLE = 2'd0,
    RUN_DOWN = 2'd1,
    RUN_UP   = 2'd2
  } run_mode_e;

  typedef enum logic [1:0] {
    CFG_SHIFT_PERIOD  = 2'd0,
    CFG_BLINK_PERIOD  = 2'd1,
    CFG_LONG_PRESS    = 2'd2,
    CFG_DOUBLE_WINDOW = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CntW-1:0] shift_period;
    logic [CntW-1:0] blink_period;
    logic [CntW-1:0] long_press_ticks;
    logic [CntW-1:0] double_click_window;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    gesture_e gesture;
  } push_t;

  typedef struct packed {
    logic     valid;
    gesture_e gesture;
  } pop_t;

endpackage

FILE: design/cglc_if.sv
// Interfaces: key sample channel and LED result channel.
`timescale 1ns / 1ps
interface cglc_in_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink (input valid, input key_level, output ready);
endinterface

interface cglc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_pattern;
  logic [1:0] gesture;
  logic [1:0] running;

  modport source (output valid, output led_pattern, output gesture, output running,
                  input ready);
  modport sink (input valid, input led_pattern, input gesture, input running,
                output ready);
endinterface

FILE: design/cglc_front.sv
// Front: key phase machine that classifies each key sample word into a gesture.
`timescale 1ns / 1ps
module cglc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       key_level_i,
  input  logic [cglc_pkg::CntW-1:0]  long_press_ticks_i,
  input  logic [cglc_pkg::CntW-1:0]  double_click_window_i,
  output cglc_pkg::push_t            push_o
);
  import cglc_pkg::*;

  key_phase_e      phase_q, phase_d;
  logic [CntW-1:0] press_q, press_d;
  logic [CntW-1:0] gap_q, gap_d;
  logic [CntW-1:0] press_inc, gap_inc;
  logic            pressed;
  gesture_e        gesture;

  assign pressed = ~key_level_i;
  assign press_inc = CntW'(press_q + 1'b1);
  assign gap_inc = CntW'(gap_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= KEY_WAIT_PRESS;
      press_q <= '0;
      gap_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      press_q <= press_d;
      gap_q   <= gap_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    press_d = press_q;
    gap_d   = gap_q;
    gesture = GEST_NONE;
    case (phase_q)
      KEY_WAIT_PRESS: begin
        if (pressed) begin
          press_d = '0;
          phase_d = KEY_HELD;
        end
      end
      KEY_HELD: begin
        if (pressed) begin
          press_d = press_inc;
          if (press_inc >= long_press_ticks_i) begin
            gesture = GEST_LONG;
            phase_d = KEY_WAIT_RELEASE;
          end
        end else begin
          gap_d   = '0;
          phase_d = KEY_WAIT_SECOND;
        end
      end
      KEY_WAIT_SECOND: begin
        gap_d = gap_inc;
        if (pressed) begin
          gesture = GEST_DOUBLE;
          phase_d = KEY_WAIT_RELEASE;
        end else if (gap_inc >= double_click_window_i) begin
          gesture = GEST_SINGLE;
          phase_d = KEY_WAIT_PRESS;
        end
      end
      KEY_WAIT_RELEASE: begin
        if (!pressed) begin
          phase_d = KEY_WAIT_PRESS;
        end
      end
      default: begin
        phase_d = KEY_WAIT_PRESS;
      end
    endcase
  end

  assign push_o = '{valid: accept_i, gesture: gesture};

endmodule

FILE: design/cglc_queue.sv
// Queue: short gesture FIFO between the key front and the chaser back.
`timescale 1ns / 1ps
module cglc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cglc_pkg::push_t push_i,
  input  logic            pop_i,
  output logic            full_o,
  output cglc_pkg::pop_t  head_o
);
  import cglc_pkg::*;

  gesture_e           mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, wr_d;
  logic [QPtrW-1:0]   rd_q, rd_d;
  logic [QPtrW:0]     cnt_q, cnt_d;
  logic               do_pop;

  assign full_o = (cnt_q == (QPtrW + 1)'(QDepth));
  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.valid) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : QPtrW'(wr_q + 1'b1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : QPtrW'(rd_q + 1'b1);
    end
    case ({push_i.valid, do_pop})
      2'b10:   cnt_d = (QPtrW + 1)'(cnt_q + 1'b1);
      2'b01:   cnt_d = (QPtrW + 1)'(cnt_q - 1'b1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.gesture;
    end
  end

  assign head_o = '{valid: (cnt_q != '0), gesture: mem_q[rd_q]};

endmodule

FILE: design/cglc_back.sv
// Back: chaser, step and blink timers, and the result output register.
`timescale 1ns / 1ps
module cglc_back #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cglc_pkg::pop_t            head_i,
  output logic                      pop_o,
  input  logic [cglc_pkg::CntW-1:0] shift_period_i,
  input  logic [cglc_pkg::CntW-1:0] blink_period_i,
  cglc_out_if.source                out_o
);
  import cglc_pkg::*;

  localparam int unsigned IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  run_mode_e        mode_q, mode_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [PortW-1:0] pat_q, pat_d;
  logic [PortW-1:0] shown_q, shown_d;
  logic [CntW-1:0]  blink_tick_q, blink_tick_d;
  logic [CntW-1:0]  step_cnt_q, step_cnt_d;
  logic             blink_on_q, blink_on_d;
  logic             out_valid_q;
  logic [PortW-1:0] led_q;
  gesture_e         gest_q;
  run_mode_e        run_q;

  logic [CntW-1:0]  step_inc, blink_inc;
  logic             shift_due;
  logic [IdxW-1:0]  idx_step;
  logic [PortW-1:0] lit_cur, lit_step;

  function automatic logic [PortW-1:0] lit_bit(input logic [IdxW-1:0] idx);
    logic [4:0]       idx_ext;
    logic [PortW-1:0] bits;
    idx_ext = 5'(idx);
    for (int i = 0; i < PortW; i++) begin
      bits[i] = (idx_ext == 5'(i));
    end
    return bits;
  endfunction

  assign pop_o = head_i.valid && (!out_valid_q || out_o.ready);

  assign step_inc  = CntW'(step_cnt_q + 1'b1);
  assign blink_inc = CntW'(blink_tick_q + 1'b1);
  assign lit_cur   = lit_bit(idx_q);
  assign lit_step  = lit_bit(idx_step);

  always_comb begin
    if (mode_q == RUN_UP) begin
      idx_step = (idx_q == IdxW'(LED_COUNT - 1)) ? '0 : IdxW'(idx_q + 1'b1);
    end else begin
      idx_step = (idx_q == '0) ? IdxW'(LED_COUNT - 1) : IdxW'(idx_q - 1'b1);
    end
  end

  always_comb begin
    mode_d       = mode_q;
    idx_d        = idx_q;
    pat_d        = pat_q;
    shown_d      = shown_q;
    blink_tick_d = blink_inc;
    step_cnt_d   = step_cnt_q;
    blink_on_d   = blink_on_q;
    shift_due    = 1'b0;

    if (mode_q != RUN_IDLE) begin
      step_cnt_d = step_inc;
      if (step_inc >= shift_period_i) begin
        step_cnt_d = '0;
        shift_due  = 1'b1;
      end
    end

    if (blink_inc >= blink_period_i) begin
      blink_tick_d = '0;
      blink_on_d   = ~blink_on_q;
      shown_d      = blink_on_q ? (pat_q | lit_cur) : pat_q;
    end else if (blink_on_q) begin
      shown_d = pat_q;
    end

    if (head_i.gesture == GEST_LONG) begin
      mode_d     = RUN_IDLE;
      idx_d      = '0;
      pat_d      = PatternRst;
      blink_on_d = 1'b1;
      shown_d    = PatternRst;
    end else if (mode_q != RUN_IDLE) begin
      if (shift_due) begin
        idx_d = idx_step;
        pat_d = ~lit_step;
      end
    end else if (head_i.gesture == GEST_SINGLE || head_i.gesture == GEST_DOUBLE) begin
      pat_d  = ~lit_cur;
      mode_d = (head_i.gesture == GEST_SINGLE) ? RUN_DOWN : RUN_UP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= RUN_IDLE;
      idx_q        <= '0;
      pat_q        <= PatternRst;
      shown_q      <= PatternRst;
      blink_tick_q <= '0;
      step_cnt_q   <= '0;
      blink_on_q   <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q       <= mode_d;
        idx_q        <= idx_d;
        pat_q        <= pat_d;
        shown_q      <= shown_d;
        blink_tick_q <= blink_tick_d;
        step_cnt_q   <= step_cnt_d;
        blink_on_q   <= blink_on_d;
        out_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      led_q  <= shown_d;
      gest_q <= head_i.gesture;
      run_q  <= mode_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.led_pattern = led_q;
  assign out_o.gesture     = gest_q;
  assign out_o.running     = run_q;

endmodule

FILE: design/click_gesture_led_chaser.sv
// Top level: configuration registers and the front, queue and back of the chaser.
`timescale 1ns / 1ps
// One key sample word is accepted per clock while the gesture queue is not
// full, and one result word leaves per clock while a gesture is queued and
// the output side is ready; a word's result passes through the gesture queue
// and then the result output register. The two-entry gesture queue between
// the key phase machine and the chaser update lets either side stall on its own.
// The user must write registers through cfg_we_i, cfg_idx_i and cfg_data_i
// only while no words are in flight; the block itself does not enforce it.
module click_gesture_led_chaser #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [cglc_pkg::CntW-1:0] cfg_data_i,
  cglc_in_if.sink                   in_i,
  cglc_out_if.source                out_o
);
  import cglc_pkg::*;

  cfg_t  cfg_q;
  push_t push;
  pop_t  head;
  logic  q_full;
  logic  pop;
  logic  accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shift_period        <= ShiftPeriodRst;
      cfg_q.blink_period        <= BlinkPeriodRst;
      cfg_q.long_press_ticks    <= LongPressRst;
      cfg_q.double_click_window <= DoubleWindowRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SHIFT_PERIOD:  cfg_q.shift_period        <= cfg_data_i;
        CFG_BLINK_PERIOD:  cfg_q.blink_period        <= cfg_data_i;
        CFG_LONG_PRESS:    cfg_q.long_press_ticks    <= cfg_data_i;
        CFG_DOUBLE_WINDOW: cfg_q.double_click_window <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_i.ready = ~q_full;
  assign accept     = in_i.valid & ~q_full;

  cglc_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .accept_i              (accept),
    .key_level_i           (in_i.key_level),
    .long_press_ticks_i    (cfg_q.long_press_ticks),
    .double_click_window_i (cfg_q.double_click_window),
    .push_o                (push)
  );

  cglc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  cglc_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .shift_period_i (cfg_q.shift_period),
    .blink_period_i (cfg_q.blink_period),
    .out_o          (out_o)
  );

endmodule
